// File: src/skf_pkg.sv
`timescale 1ns / 1ps

package skf_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned GAIN_W  = 17;
    localparam int unsigned DEN_W   = DATA_W + 1;
    localparam int unsigned REM_W   = DATA_W + 2;
    localparam int unsigned ALU_W   = 51;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned STEPS   = GAIN_W;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned ADDR_W  = 3;

    localparam logic [CNT_W-1:0]  CNT_FIRST = CNT_W'(STEPS - 1);
    localparam logic [GAIN_W-1:0] ONE_Q16   = GAIN_W'(65536);

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET     = DATA_W'(66);
    localparam logic [DATA_W-1:0] MEASUREMENT_NOISE_RESET = DATA_W'(65536);

    // Register index as seen on paddr[2] (word-aligned map).
    localparam logic REG_PROCESS_NOISE     = 1'b0;
    localparam logic REG_MEASUREMENT_NOISE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL_EST,
        ST_MUL_COV,
        ST_DONE
    } state_t;

endpackage

// File: src/scalar_kalman_filter.sv
`timescale 1ns / 1ps

// Scalar Kalman filter, signed Q16.16 measurements in, corrected estimate
// and the Q1.16 gain out (65536 means one). A transfer runs from acceptance
// until the next measurement can be accepted, in this order: a setup step,
// 17 restoring-division steps for the gain, 17 shift-add steps for the
// estimate correction, 17 for the new covariance, and a last step that hands
// the result to the output register once that register is free. All three
// iterative phases run through a single shared 51-bit adder. The block
// takes no new measurement while a transfer is in progress. The output
// register holds a finished result until it is taken, and a new measurement
// is accepted while it waits. The process and measurement noise registers
// are at byte addresses 0 and 4 and must only be written while idle.
module scalar_kalman_filter (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  measurement,

    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  estimate,
    output logic [16:0]         gain,
    output logic                zero_denominator,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    skf_pkg::state_t state_reg, state_next;

    logic [skf_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [31:0]                pn_reg, pn_next;
    logic [31:0]                mn_reg, mn_next;
    logic [31:0]                estimate_reg, estimate_next;
    logic [31:0]                covariance_reg, covariance_next;
    logic                       out_valid_reg, out_valid_next;

    logic [31:0]                meas_reg, meas_next;
    logic [31:0]                prior_reg, prior_next;
    logic [skf_pkg::DEN_W-1:0]  denom_reg, denom_next;
    logic                       zden_reg, zden_next;
    logic [skf_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [16:0]                mq_reg, mq_next;
    logic [16:0]                gain_reg, gain_next;
    logic [skf_pkg::ALU_W-1:0]  mcand_reg, mcand_next;
    logic [skf_pkg::ALU_W-1:0]  acc_reg, acc_next;
    logic [31:0]                est_new_reg, est_new_next;
    logic [31:0]                cov_new_reg, cov_new_next;
    logic [31:0]                out_est_reg, out_est_next;
    logic [16:0]                out_gain_reg, out_gain_next;
    logic                       out_zden_reg, out_zden_next;

    // Shared adder/subtractor.
    logic [skf_pkg::ALU_W-1:0]  alu_a, alu_b, alu_sum;
    logic                       alu_sub;

    logic                       in_xfer;
    logic                       cfg_write;
    logic [32:0]                prior_sum;
    logic [31:0]                prior_sat;
    logic [skf_pkg::DEN_W-1:0]  denom_sum;
    logic [32:0]                diff;
    logic [skf_pkg::REM_W:0]    div_shift;
    logic                       div_neg;
    logic [16:0]                quo_full;
    logic [16:0]                gain_sel;
    logic [34:0]                corr;
    logic [34:0]                est_sum;
    logic [31:0]                est_sat;

    assign in_stall         = (state_reg != skf_pkg::ST_IDLE);
    assign in_xfer          = in_valid && !in_stall;
    assign out_valid        = out_valid_reg;
    assign estimate         = out_est_reg;
    assign gain             = out_gain_reg;
    assign zero_denominator = out_zden_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == skf_pkg::REG_MEASUREMENT_NOISE) ? mn_reg : pn_reg;

    assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + {{(skf_pkg::ALU_W-1){1'b0}}, alu_sub};

    // Setup arithmetic for a new measurement.
    assign prior_sum = {1'b0, covariance_reg} + {1'b0, pn_reg};
    assign prior_sat = prior_sum[32] ? 32'hFFFF_FFFF : prior_sum[31:0];
    assign denom_sum = {1'b0, prior_sat} + {1'b0, mn_reg};

    // Restoring division step: bring in the next numerator bit, which is
    // the low bit of the prior on the first step and zero afterward.
    assign div_shift = {rem_reg, (cnt_reg == skf_pkg::CNT_FIRST) ? prior_reg[0] : 1'b0};
    assign div_neg   = alu_sum[skf_pkg::ALU_W-1];
    assign quo_full  = {mq_reg[15:0], !div_neg};
    assign gain_sel  = zden_reg ? 17'd0 : quo_full;
    assign diff      = {meas_reg[31], meas_reg} - {estimate_reg[31], estimate_reg};

    // The arithmetic shift of the product rounds toward minus infinity.
    assign corr    = alu_sum[50:16];
    assign est_sum = {{3{estimate_reg[31]}}, estimate_reg} + corr;
    always_comb
    begin
        if (est_sum[34:31] == 4'b0000 || est_sum[34:31] == 4'b1111)
        begin
            est_sat = est_sum[31:0];
        end
        else
        begin
            est_sat = est_sum[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pn_next         = pn_reg;
        mn_next         = mn_reg;
        estimate_next   = estimate_reg;
        covariance_next = covariance_reg;
        out_valid_next  = out_valid_reg && out_stall;
        meas_next       = meas_reg;
        prior_next      = prior_reg;
        denom_next      = denom_reg;
        zden_next       = zden_reg;
        rem_next        = rem_reg;
        mq_next         = mq_reg;
        gain_next       = gain_reg;
        mcand_next      = mcand_reg;
        acc_next        = acc_reg;
        est_new_next    = est_new_reg;
        cov_new_next    = cov_new_reg;
        out_est_next    = out_est_reg;
        out_gain_next   = out_gain_reg;
        out_zden_next   = out_zden_reg;
        alu_a           = '0;
        alu_b           = '0;
        alu_sub         = 1'b0;

        if (cfg_write)
        begin
            if (paddr[2] == skf_pkg::REG_MEASUREMENT_NOISE)
            begin
                mn_next = pwdata;
            end
            else
            begin
                pn_next = pwdata;
            end
        end

        case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    meas_next  = measurement;
                    prior_next = prior_sat;
                    denom_next = denom_sum;
                    zden_next  = (denom_sum == '0);
                    rem_next   = {3'b000, prior_sat[31:1]};
                    mq_next    = '0;
                    cnt_next   = skf_pkg::CNT_FIRST;
                    state_next = skf_pkg::ST_DIV;
                end
            end

            skf_pkg::ST_DIV:
            begin
                alu_a    = {{(skf_pkg::ALU_W-skf_pkg::REM_W-1){1'b0}}, div_shift};
                alu_b    = {{(skf_pkg::ALU_W-skf_pkg::DEN_W){1'b0}}, denom_reg};
                alu_sub  = 1'b1;
                rem_next = div_neg ? div_shift[skf_pkg::REM_W-1:0]
                                   : alu_sum[skf_pkg::REM_W-1:0];
                mq_next  = quo_full;
                if (cnt_reg == '0)
                begin
                    gain_next  = gain_sel;
                    mq_next    = gain_sel;
                    mcand_next = {{(skf_pkg::ALU_W-33){diff[32]}}, diff};
                    acc_next   = '0;
                    cnt_next   = skf_pkg::CNT_FIRST;
                    state_next = skf_pkg::ST_MUL_EST;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            skf_pkg::ST_MUL_EST, skf_pkg::ST_MUL_COV:
            begin
                alu_a      = acc_reg;
                alu_b      = mq_reg[0] ? mcand_reg : '0;
                acc_next   = alu_sum;
                mcand_next = {mcand_reg[skf_pkg::ALU_W-2:0], 1'b0};
                mq_next    = {1'b0, mq_reg[16:1]};
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
                else if (state_reg == skf_pkg::ST_MUL_EST)
                begin
                    est_new_next = est_sat;
                    mq_next      = skf_pkg::ONE_Q16 - gain_reg;
                    mcand_next   = {{(skf_pkg::ALU_W-32){1'b0}}, prior_reg};
                    acc_next     = '0;
                    cnt_next     = skf_pkg::CNT_FIRST;
                    state_next   = skf_pkg::ST_MUL_COV;
                end
                else
                begin
                    cov_new_next = alu_sum[47:16];
                    state_next   = skf_pkg::ST_DONE;
                end
            end

            skf_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_est_next    = est_new_reg;
                    out_gain_next   = gain_reg;
                    out_zden_next   = zden_reg;
                    out_valid_next  = 1'b1;
                    estimate_next   = est_new_reg;
                    covariance_next = cov_new_reg;
                    state_next      = skf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = skf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= skf_pkg::ST_IDLE;
            cnt_reg        <= '0;
            pn_reg         <= skf_pkg::PROCESS_NOISE_RESET;
            mn_reg         <= skf_pkg::MEASUREMENT_NOISE_RESET;
            estimate_reg   <= '0;
            covariance_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pn_reg         <= pn_next;
            mn_reg         <= mn_next;
            estimate_reg   <= estimate_next;
            covariance_reg <= covariance_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg     <= meas_next;
        prior_reg    <= prior_next;
        denom_reg    <= denom_next;
        zden_reg     <= zden_next;
        rem_reg      <= rem_next;
        mq_reg       <= mq_next;
        gain_reg     <= gain_next;
        mcand_reg    <= mcand_next;
        acc_reg      <= acc_next;
        est_new_reg  <= est_new_next;
        cov_new_reg  <= cov_new_next;
        out_est_reg  <= out_est_next;
        out_gain_reg <= out_gain_next;
        out_zden_reg <= out_zden_next;
    end

`ifndef SYNTHESIS
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gain <= skf_pkg::ONE_Q16))
        else $error("gain above one");

    a_zero_den_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_denominator) |-> (gain == 17'd0))
        else $error("nonzero gain with zero denominator");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (in_stall && !$rose(out_valid)))
        else $error("filter ready or finished right after accepting a measurement");
`endif

endmodule

// File: verif/skf_checker.sv
`timescale 1ns / 1ps

module skf_checker
    import skf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [DATA_W-1:0] measurement,

    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [DATA_W-1:0] estimate,
    input  logic [GAIN_W-1:0]        gain,
    input  logic                     zero_denominator,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,

    output int                       mismatches,
    output int                       outstanding,
    output int                       results_checked
);

    localparam longint UNITY    = 65536;
    localparam longint U32_MAX  = 64'h0000_0000_FFFF_FFFF;
    localparam longint S32_MAX  = 2147483647;
    localparam longint S32_MIN  = -S32_MAX - 1;

    typedef struct {
        logic signed [DATA_W-1:0] estimate;
        logic [GAIN_W-1:0]        gain;
        logic                     zero_den;
    } filter_out_t;

    logic signed [DATA_W-1:0] est_state;
    logic [DATA_W-1:0]        cov_state;
    logic [DATA_W-1:0]        q_noise;
    logic [DATA_W-1:0]        r_noise;
    filter_out_t              expected_q[$];
    int                       fails;
    int                       checked;

    // One predict/correct step; updates the kept estimate and covariance.
    function automatic filter_out_t filter_update(input logic signed [DATA_W-1:0] sample);
        longint      prior;
        longint      denom;
        longint      k;
        longint      corr;
        longint      nxt;
        filter_out_t r;
        prior = longint'(cov_state) + longint'(q_noise);
        if (prior > U32_MAX)
            prior = U32_MAX;
        denom = prior + longint'(r_noise);
        r.zero_den = (denom == 0);
        k = (denom == 0) ? 0 : (prior <<< 16) / denom;
        if (k > UNITY)
            k = UNITY;
        // Arithmetic shift of the signed product rounds toward minus infinity.
        corr = (k * (longint'(sample) - longint'(est_state))) >>> 16;
        nxt = longint'(est_state) + corr;
        if (nxt > S32_MAX)
            nxt = S32_MAX;
        if (nxt < S32_MIN)
            nxt = S32_MIN;
        est_state = nxt[DATA_W-1:0];
        cov_state = DATA_W'(((UNITY - k) * prior) >> 16);
        r.estimate = est_state;
        r.gain = k[GAIN_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        filter_out_t want;
        if (!rst_n)
        begin
            q_noise = PROCESS_NOISE_RESET;
            r_noise = MEASUREMENT_NOISE_RESET;
            est_state = '0;
            cov_state = '0;
            expected_q.delete();
            fails = 0;
            checked = 0;
            mismatches <= 0;
            outstanding <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result: estimate %0d gain %0d zero_denominator %0b",
                             $time, estimate, gain, zero_denominator);
                    fails++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    checked++;
                    if (estimate !== want.estimate)
                    begin
                        $display("%0t: estimate mismatch: expected %0d, got %0d",
                                 $time, want.estimate, estimate);
                        fails++;
                    end
                    if (gain !== want.gain)
                    begin
                        $display("%0t: gain mismatch: expected %0d, got %0d",
                                 $time, want.gain, gain);
                        fails++;
                    end
                    if (zero_denominator !== want.zero_den)
                    begin
                        $display("%0t: zero_denominator mismatch: expected %0b, got %0b",
                                 $time, want.zero_den, zero_denominator);
                        fails++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_q.push_back(filter_update(measurement));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_PROCESS_NOISE:     q_noise = pwdata;
                    REG_MEASUREMENT_NOISE: r_noise = pwdata;
                endcase
            end
            mismatches <= fails;
            outstanding <= expected_q.size();
            results_checked <= checked;
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import skf_pkg::*;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [DATA_W-1:0] measurement;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DATA_W-1:0] estimate;
    logic [GAIN_W-1:0]        gain;
    logic                     zero_denominator;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;

    int mismatches;
    int outstanding;
    int results_checked;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_cycles;
    int items_sent;
    int settings_written;
    logic hold_req;
    logic hold_taken;

    scalar_kalman_filter u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .measurement      (measurement),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .estimate         (estimate),
        .gain             (gain),
        .zero_denominator (zero_denominator),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    skf_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .measurement      (measurement),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .estimate         (estimate),
        .gain             (gain),
        .zero_denominator (zero_denominator),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .results_checked  (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side: a requested hold-off takes priority over random stalls.
    initial
    begin
        out_stall = 1'b0;
        hold_cycles = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_cycles = 600;
                hold_taken = 1'b1;
            end
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic send_measurement(input logic signed [DATA_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        measurement <= value;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    // Stop offering and wait until every expected result has been taken.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic index, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input logic [DATA_W-1:0] q_val, input logic [DATA_W-1:0] r_val);
        wait_idle();
        write_reg(REG_PROCESS_NOISE, q_val);
        write_reg(REG_MEASUREMENT_NOISE, r_val);
        settings_written++;
    endtask

    initial
    begin
        logic signed [DATA_W-1:0] sample;
        logic signed [DATA_W-1:0] level;
        logic signed [DATA_W-1:0] noise;
        logic [DATA_W-1:0]        q_val;
        logic [DATA_W-1:0]        r_val;
        int                       noise_shift;

        rst_n = 1'b0;
        in_valid = 1'b0;
        measurement = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_req = 1'b0;
        items_sent = 0;
        settings_written = 0;
        tx_idle_pct = 35;
        rx_idle_pct = 61;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset noise values with extreme samples.
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        send_measurement(32'sh0000_0000);
        send_measurement(-32'sd1);
        send_measurement(32'sd1);

        // No noise at all: one step at unity gain collapses the covariance,
        // after which the denominator is zero.
        configure(32'h0000_0000, 32'h0000_0000);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        send_measurement(-32'sd1);

        // Zero measurement noise: the estimate follows the sample exactly.
        configure(32'h0000_0001, 32'h0000_0000);
        send_measurement(32'sh8000_0000);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh1234_5678);

        // Largest noise values; the prior covariance saturates.
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(-32'sd1);

        configure(32'hFFFF_FFFF, 32'h0000_0000);
        send_measurement(32'sh8000_0000);
        send_measurement(32'sh7FFF_FFFF);

        configure(32'h0000_0000, 32'hFFFF_FFFF);
        send_measurement(32'sh7FFF_FFFF);
        send_measurement(32'sh8000_0000);
        send_measurement(32'sh5555_5555);
        send_measurement(-32'sh5555_5556);

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 61 : 0;
            rx_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 35 : 0;
            for (int seg = 0; seg < 6; seg++)
            begin
                case ($urandom_range(5))
                    0:       q_val = '0;
                    1:       q_val = 32'd1;
                    2:       q_val = PROCESS_NOISE_RESET;
                    3:       q_val = '1;
                    4:       q_val = $urandom & 32'h000F_FFFF;
                    default: q_val = $urandom;
                endcase
                case ($urandom_range(5))
                    0:       r_val = '0;
                    1:       r_val = 32'd1;
                    2:       r_val = MEASUREMENT_NOISE_RESET;
                    3:       r_val = '1;
                    4:       r_val = $urandom & 32'h00FF_FFFF;
                    default: r_val = $urandom;
                endcase
                configure(q_val, r_val);
                level = $urandom;
                level = level >>> $urandom_range(16, 0);
                noise_shift = $urandom_range(27, 8);
                for (int n = 0; n < 100; n++)
                begin
                    // Mostly a noisy constant signal, with some wild samples.
                    case ($urandom_range(9))
                        0, 1:    sample = $urandom;
                        2:       sample = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                        default:
                        begin
                            noise = $urandom;
                            sample = level + (noise >>> noise_shift);
                        end
                    endcase
                    send_measurement(sample);
                    // Hold results back long enough for the block to stall its input.
                    if (phase == 2 && seg == 0 && n == 0)
                        hold_req = 1'b1;
                end
            end
        end

        wait_idle();
        repeat (60) @(posedge clk);
        $display("Covered %0d measurements over %0d noise settings; %0d results compared.",
                 items_sent, settings_written, results_checked);
        $display("Included extreme samples and noise values, unity gain and zero denominator.");
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
